FILE: rtl/cam_spring_restoring_torque_unit_defines.svh
// ---------------------------------------------------------------------------
// Cam spring torque assertion macros
// Concurrent check wrappers, active in simulation and empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef CAM_SPRING_RESTORING_TORQUE_UNIT_DEFINES_SVH
`define CAM_SPRING_RESTORING_TORQUE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// check a property on every rising clock edge outside reset
`define CRT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("crt assertion failed");
// check a property on every rising clock edge, reset included
`define CRT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("crt assertion failed");
`else
`define CRT_ASSERT(lbl, prop)
`define CRT_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: rtl/crt_pkg.sv
// ---------------------------------------------------------------------------
// Cam spring torque package
// Shared constants, payload types and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package crt_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned WRAP_STEPS = 10;

  localparam logic [22:0] PI_Q20 = 23'd3294199;
  localparam logic [22:0] TWO_PI_Q20 = 23'd6588398;
  localparam logic signed [22:0] WRAP_MAX = 23'sd3294199;
  localparam logic signed [22:0] WRAP_MIN = -23'sd3294199;
  // 326 * 2pi, lifts any int32 angle to a non-negative value
  localparam logic [33:0] WRAP_OFFSET = 34'd2147817748;

  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

  localparam logic [14:0] DEAD_BAND_RST = 15'd1425;
  localparam logic [23:0] SPRING_K_RST = 24'd128000;
  localparam logic [15:0] REEL_RADIUS_RST = 16'd983;
  localparam logic [15:0] CAM_RADIUS_RST = 16'd2294;

  typedef enum logic [1:0] {
    REG_DEAD_BAND,
    REG_SPRING_K,
    REG_REEL_RADIUS,
    REG_CAM_RADIUS
  } reg_index_t;

  typedef struct packed {
    logic [33:0] rem;
    logic signed [31:0] reel;
  } wrap_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_vec_t;

  typedef struct packed {
    logic neg;
    logic signed [33:0] z;
  } start_t;

  typedef struct packed {
    logic signed [22:0] w;
    logic inner;
    logic neg_cos;
    logic signed [31:0] reel;
  } side_t;

  function automatic logic [29:0] atan_q30(input int unsigned i);
    logic [29:0] v;
    case (i)
      0: v = 30'd843314856;
      1: v = 30'd497837829;
      2: v = 30'd263043836;
      3: v = 30'd133525158;
      4: v = 30'd67021686;
      5: v = 30'd33543515;
      6: v = 30'd16775850;
      7: v = 30'd8388437;
      8: v = 30'd4194282;
      9: v = 30'd2097149;
      10: v = 30'd1048575;
      11: v = 30'd524287;
      12: v = 30'd262143;
      13: v = 30'd131071;
      14: v = 30'd65535;
      15: v = 30'd32767;
      16: v = 30'd16383;
      17: v = 30'd8191;
      18: v = 30'd4095;
      19: v = 30'd2047;
      20: v = 30'd1023;
      21: v = 30'd511;
      22: v = 30'd255;
      23: v = 30'd127;
      default: v = '0;
    endcase
    return v;
  endfunction

  // fold an angle above pi/2 back to pi - angle and flag the cosine sign
  function automatic start_t fold_angle(input logic [31:0] ang);
    start_t s;
    logic signed [33:0] z;
    z = $signed({2'b00, ang});
    if (z > HALF_PI_Q30) begin
      s.z = PI_Q30 - z;
      s.neg = 1'b1;
    end else begin
      s.z = z;
      s.neg = 1'b0;
    end
    return s;
  endfunction

endpackage

FILE: rtl/crt_if.sv
// ---------------------------------------------------------------------------
// Cam spring torque channels
// Valid/ready channels for angle requests and torque results.
// ---------------------------------------------------------------------------
interface crt_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] steer_angle;
  logic signed [31:0] reel_angle;
  modport source (output valid, output steer_angle, output reel_angle, input ready);
  modport sink (input valid, input steer_angle, input reel_angle, output ready);
endinterface

interface crt_out_if;
  logic valid;
  logic ready;
  logic signed [22:0] wrapped_angle;
  logic signed [31:0] torque;
  logic clipped;
  modport source (output valid, output wrapped_angle, output torque, output clipped,
                  input ready);
  modport sink (input valid, input wrapped_angle, input torque, input clipped,
                output ready);
endinterface

FILE: rtl/cam_spring_restoring_torque_unit.sv
// Throughput: one request per cycle unless the result stalls; the two CORDIC chains run side by side.
// A stalled result holds every stage; a new request enters whenever the
// output register is empty or being taken.
// Reset (rst, synchronous): clears all stage valid bits and loads the
// register defaults; payload stages are not reset.
// ---------------------------------------------------------------------------
// Cam spring restoring torque unit
// Wraps the steer angle, runs sin/cos through chains of CORDIC cells and
// forms the saturated Q16.16 restoring torque of a cam spring.
// ---------------------------------------------------------------------------
`include "cam_spring_restoring_torque_unit_defines.svh"

module cam_spring_restoring_torque_unit #(
  parameter int unsigned CORDIC_STAGES = crt_pkg::CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [23:0] wr_data,
  crt_in_if.sink      req,
  crt_out_if.source   rsp
);
  import crt_pkg::*;

  // input reg, wrap cells, fold, start, CORDIC cells, seven tail stages
  localparam int unsigned DEPTH = CORDIC_STAGES + WRAP_STEPS + 10;

  // configuration registers
  logic [14:0] dead_band;
  logic [23:0] spring_k;
  logic [15:0] reel_radius;
  logic [15:0] cam_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_band   <= DEAD_BAND_RST;
      spring_k    <= SPRING_K_RST;
      reel_radius <= REEL_RADIUS_RST;
      cam_radius  <= CAM_RADIUS_RST;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_DEAD_BAND:   dead_band   <= wr_data[14:0];
        REG_SPRING_K:    spring_k    <= wr_data;
        REG_REEL_RADIUS: reel_radius <= wr_data[15:0];
        REG_CAM_RADIUS:  cam_radius  <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  // every stage advances together; hold all of them while the result stalls
  logic adv;
  logic [DEPTH-1:0] vld;

  assign adv = !rsp.valid || rsp.ready;
  assign req.ready = adv;
  assign rsp.valid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[DEPTH-2:0], req.valid};
    end
  end

  // ---- wrap: offset to non-negative, then ten restoring steps ----
  wrap_t wrap_pipe [0:WRAP_STEPS];

  always_ff @(posedge clk) begin
    if (adv) begin
      wrap_pipe[0].rem  <= 34'(req.steer_angle) + WRAP_OFFSET;
      wrap_pipe[0].reel <= req.reel_angle;
    end
  end

  for (genvar i = 0; i < WRAP_STEPS; i++) begin : g_wrap
    crt_wrap_cell #(.STEP(WRAP_STEPS - 1 - i)) u_cell (
      .clk   (clk),
      .en    (adv),
      .d_in  (wrap_pipe[i]),
      .d_out (wrap_pipe[i+1])
    );
  end

  // ---- fold into [-pi, pi] and take the magnitude ----
  logic [22:0] rem23;
  logic [22:0] w_c;
  logic [22:0] t_c;
  logic signed [22:0] wf_w;
  logic [31:0] wf_t30;
  logic signed [31:0] wf_reel;

  assign rem23 = wrap_pipe[WRAP_STEPS].rem[22:0];
  assign w_c = (rem23 > PI_Q20) ? rem23 - TWO_PI_Q20 : rem23;
  assign t_c = w_c[22] ? 23'(-w_c) : w_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      wf_w    <= $signed(w_c);
      wf_t30  <= {t_c[21:0], 10'b0};
      wf_reel <= wrap_pipe[WRAP_STEPS].reel;
    end
  end

  // ---- pick the CORDIC angles: primary t or t-a, secondary a ----
  logic [31:0] a30;
  logic inner_c;
  logic [31:0] ang_p;
  start_t st_p;
  start_t st_q;

  cordic_vec_t cp [0:CORDIC_STAGES];
  cordic_vec_t cq [0:CORDIC_STAGES];
  side_t sb [0:CORDIC_STAGES];

  assign a30 = {dead_band, 17'b0};
  // the boundary t == a takes the outer branch
  assign inner_c = wf_t30 < a30;
  assign ang_p = inner_c ? wf_t30 : wf_t30 - a30;
  assign st_p = fold_angle(ang_p);
  assign st_q = fold_angle(a30);

  always_ff @(posedge clk) begin
    if (adv) begin
      cp[0].x <= GAIN_Q30;
      cp[0].y <= '0;
      cp[0].z <= st_p.z;
      cq[0].x <= GAIN_Q30;
      cq[0].y <= '0;
      cq[0].z <= st_q.z;
      sb[0].w       <= wf_w;
      sb[0].inner   <= inner_c;
      sb[0].neg_cos <= st_p.neg;
      sb[0].reel    <= wf_reel;
    end
  end

  // ---- two chains of CORDIC cells; sideband rides alongside ----
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    crt_cordic_cell #(.STAGE(i)) u_cell_p (
      .clk   (clk),
      .en    (adv),
      .v_in  (cp[i]),
      .v_out (cp[i+1])
    );
    crt_cordic_cell #(.STAGE(i)) u_cell_q (
      .clk   (clk),
      .en    (adv),
      .v_in  (cq[i]),
      .v_out (cq[i+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        sb[i+1] <= sb[i];
      end
    end
  end

  // ---- tail 1: lift terms, preload and scaled cosine ----
  logic signed [16:0] rs;
  logic signed [16:0] rr;
  logic signed [50:0] mp;
  logic signed [50:0] mq;
  logic signed [48:0] mpre;
  logic signed [33:0] cos_c;
  logic signed [28:0] s1_tp;
  logic signed [28:0] s1_tq;
  logic signed [36:0] s1_pre;
  logic signed [19:0] s1_c14;
  logic signed [22:0] s1_w;

  assign rs = $signed({1'b0, cam_radius});
  assign rr = $signed({1'b0, reel_radius});
  assign mp = rs * cp[CORDIC_STAGES].y;
  assign mq = rs * cq[CORDIC_STAGES].y;
  assign mpre = rr * sb[CORDIC_STAGES].reel;
  assign cos_c = sb[CORDIC_STAGES].neg_cos ? -cp[CORDIC_STAGES].x : cp[CORDIC_STAGES].x;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_tp  <= mp[50:22];
      // inside the dead band the sin(a) term drops out
      s1_tq  <= sb[CORDIC_STAGES].inner ? '0 : mq[50:22];
      s1_pre <= mpre[48:12];
      s1_c14 <= cos_c[33:14];
      s1_w   <= sb[CORDIC_STAGES].w;
    end
  end

  // ---- tail 2: spring stretch ----
  logic signed [37:0] s2_d;
  logic signed [19:0] s2_c14;
  logic signed [22:0] s2_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_d   <= 38'(s1_tp) + 38'(s1_tq) + 38'(s1_pre);
      s2_c14 <= s1_c14;
      s2_w   <= s1_w;
    end
  end

  // ---- tail 3: spring force as two partial products ----
  logic signed [24:0] ks;
  logic signed [19:0] d_hi;
  logic [41:0] s3_pl;
  logic signed [44:0] s3_ph;
  logic signed [19:0] s3_c14;
  logic signed [22:0] s3_w;

  assign ks = $signed({1'b0, spring_k});
  assign d_hi = s2_d[37:18];

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_pl  <= spring_k * s2_d[17:0];
      s3_ph  <= ks * d_hi;
      s3_c14 <= s2_c14;
      s3_w   <= s2_w;
    end
  end

  // ---- tail 4: combine partial products ----
  logic signed [63:0] kd;
  logic signed [47:0] s4_force;
  logic signed [19:0] s4_c14;
  logic signed [22:0] s4_w;

  assign kd = (64'(s3_ph) <<< 18) + $signed({22'b0, s3_pl});

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_force <= kd[63:16];
      s4_c14   <= s3_c14;
      s4_w     <= s3_w;
    end
  end

  // ---- tail 5: lever arm ----
  logic signed [64:0] rf_full;
  logic signed [48:0] s5_rf;
  logic signed [19:0] s5_c14;
  logic signed [22:0] s5_w;

  assign rf_full = rs * s4_force;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_rf  <= rf_full[64:16];
      s5_c14 <= s4_c14;
      s5_w   <= s4_w;
    end
  end

  // ---- tail 6: normal component ----
  logic signed [68:0] tq_full;
  logic signed [52:0] s6_mag;
  logic signed [22:0] s6_w;

  assign tq_full = s5_rf * s5_c14;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_mag <= tq_full[68:16];
      s6_w   <= s5_w;
    end
  end

  // ---- tail 7: sign, saturate, output register ----
  logic signed [53:0] tq_c;
  logic sat_hi;
  logic sat_lo;
  logic signed [22:0] out_w;
  logic signed [31:0] out_tq;
  logic out_clip;

  always_comb begin
    if (s6_w == '0) begin
      tq_c = '0;
    end else if (!s6_w[22]) begin
      tq_c = -54'(s6_mag);
    end else begin
      tq_c = 54'(s6_mag);
    end
  end

  assign sat_hi = tq_c > 54'sd2147483647;
  assign sat_lo = tq_c < -54'sd2147483648;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_w    <= s6_w;
      out_clip <= sat_hi || sat_lo;
      if (sat_hi) begin
        out_tq <= 32'sh7FFFFFFF;
      end else if (sat_lo) begin
        out_tq <= 32'sh80000000;
      end else begin
        out_tq <= tq_c[31:0];
      end
    end
  end

  assign rsp.wrapped_angle = out_w;
  assign rsp.torque = out_tq;
  assign rsp.clipped = out_clip;

  // ---- checks ----
  `CRT_ASSERT_ALWAYS(a_rst_empty, rst |=> !rsp.valid)
  `CRT_ASSERT(a_stall_blocks, (rsp.valid && !rsp.ready) |-> !req.ready)
  `CRT_ASSERT(a_wrap_range, rsp.valid |-> (out_w <= WRAP_MAX && out_w >= WRAP_MIN))
  `CRT_ASSERT(a_zero_angle, (rsp.valid && out_w == '0) |-> (out_tq == '0 && !out_clip))
  `CRT_ASSERT(a_clip_limit, (rsp.valid && out_clip) |-> (out_tq == 32'sh7FFFFFFF || out_tq == 32'sh80000000))

endmodule

FILE: rtl/crt_wrap_cell.sv
// ---------------------------------------------------------------------------
// Angle wrap cell
// One restoring step of the modulo-2pi reduction, registered.
// ---------------------------------------------------------------------------
module crt_wrap_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  crt_pkg::wrap_t d_in,
  output crt_pkg::wrap_t d_out
);
  import crt_pkg::*;

  localparam logic [33:0] MULT = 34'(TWO_PI_Q20) << STEP;

  wrap_t d_next;

  always_comb begin
    d_next = d_in;
    if (d_in.rem >= MULT) begin
      d_next.rem = d_in.rem - MULT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_next;
    end
  end
endmodule

FILE: rtl/crt_cordic_cell.sv
// ---------------------------------------------------------------------------
// CORDIC rotation cell
// One rotation-mode micro-rotation, registered.
// ---------------------------------------------------------------------------
module crt_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  crt_pkg::cordic_vec_t v_in,
  output crt_pkg::cordic_vec_t v_out
);
  import crt_pkg::*;

  localparam logic signed [33:0] ATAN = $signed({4'b0000, atan_q30(STAGE)});

  logic signed [33:0] dx;
  logic signed [33:0] dy;
  cordic_vec_t v_next;

  assign dx = v_in.y >>> STAGE;
  assign dy = v_in.x >>> STAGE;

  always_comb begin
    if (!v_in.z[33]) begin
      v_next.x = v_in.x - dx;
      v_next.y = v_in.y + dy;
      v_next.z = v_in.z - ATAN;
    end else begin
      v_next.x = v_in.x + dx;
      v_next.y = v_in.y - dy;
      v_next.z = v_in.z + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out <= v_next;
    end
  end
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Cam spring restoring torque testbench
// Drives angle requests through the valid/ready channel under random
// idling and back-pressure. Each accepted request is scored against an
// in-bench model of the wrap, CORDIC and torque arithmetic.
// ---------------------------------------------------------------------------
module tb_top;
  import crt_pkg::*;

  localparam int STAGES = (CORDIC_STAGES_DEF > 24) ? 24 : CORDIC_STAGES_DEF;
  localparam int DRAIN_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES = 200;
  localparam int HOLD_AT = 1500;

  typedef struct {
    logic signed [31:0] steer;
    logic signed [31:0] reel;
  } angle_req_t;

  typedef struct {
    logic signed [22:0] wrapped;
    logic signed [31:0] torque;
    logic clipped;
  } torque_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic wr_en = 1'b0;
  logic [1:0] wr_index = '0;
  logic [23:0] wr_data = '0;

  crt_in_if req ();
  crt_out_if rsp ();

  cam_spring_restoring_torque_unit dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .req(req.sink), .rsp(rsp.source)
  );

  // shadow copy of the block's registers
  logic [14:0] dead_band_r = DEAD_BAND_RST;
  logic [23:0] spring_k_r = SPRING_K_RST;
  logic [15:0] reel_radius_r = REEL_RADIUS_RST;
  logic [15:0] cam_radius_r = CAM_RADIUS_RST;

  angle_req_t pending_reqs[$];
  torque_rsp_t expected_torques[$];
  int fails = 0;
  logic quiet = 1'b0;
  logic req_fire = 1'b0;
  int cycle_count = 0;
  int stall_cycles = 0;

  const longint ATAN[24] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127};

  initial begin
    forever #2 clk = ~clk;
  end

  // Rotation-mode CORDIC on a Q30 angle in [0, 2^32); fold above pi/2.
  function automatic void cordic_sincos(input longint ang, output longint s,
                                        output longint c);
    longint x, y, z, dx, dy;
    bit flip;
    x = 652032874;
    y = 0;
    z = ang;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z = 64'sd3373259426 - z;
      flip = 1;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN[i];
      end else begin
        x += dx; y -= dy; z += ATAN[i];
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic torque_rsp_t restoring_torque(input angle_req_t a);
    torque_rsp_t o;
    longint w, t30, a30, s, c, sa, ca, lift, r, d, force_q16, rf, tq;
    r = longint'(cam_radius_r);
    w = longint'(a.steer) % 64'sd6588398;
    if (w < 0) w += 6588398;
    if (w > 3294199) w -= 6588398;
    t30 = (w < 0 ? -w : w) * 1024;
    a30 = longint'(dead_band_r) * 131072;
    if (t30 < a30) begin
      cordic_sincos(t30, s, c);
      lift = (r * s) >>> 22;
    end else begin
      cordic_sincos(a30, sa, ca);
      cordic_sincos(t30 - a30, s, c);
      lift = ((r * sa) >>> 22) + ((r * s) >>> 22);
    end
    d = lift + ((longint'(reel_radius_r) * longint'(a.reel)) >>> 12);
    force_q16 = (longint'(spring_k_r) * d) >>> 16;
    rf = (r * force_q16) >>> 16;
    tq = (rf * (c >>> 14)) >>> 16;
    if (w > 0) tq = -tq;
    else if (w == 0) tq = 0;
    o.clipped = 1'b0;
    if (tq > 64'sd2147483647) begin
      tq = 64'sd2147483647; o.clipped = 1'b1;
    end else if (tq < -64'sd2147483648) begin
      tq = -64'sd2147483648; o.clipped = 1'b1;
    end
    o.wrapped = w[22:0];
    o.torque = tq[31:0];
    return o;
  endfunction

  // Driver: present the next request at the falling edge; random gaps.
  int send_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.steer_angle <= '0;
      req.reel_angle <= '0;
    end else if (!req.valid || req_fire) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        angle_req_t a;
        a = pending_reqs.pop_front();
        req.steer_angle <= a.steer;
        req.reel_angle <= a.reel;
        req.valid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 3);
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Receiver: random ready bursts plus one long hold-off to back up the pipe.
  int hold_left = 0;
  int ready_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (cycle_count == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp.ready <= (hold_left == 1);
    end else if (ready_gap > 0) begin
      ready_gap <= ready_gap - 1;
      rsp.ready <= (ready_gap == 1);
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      ready_gap <= $urandom_range(1, 3);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted request, score each accepted result.
  always @(posedge clk) begin
    req_fire <= req.valid && req.ready && !rst;
    if (!rst) begin
      cycle_count <= cycle_count + 1;
      if (req.valid && req.ready) begin
        angle_req_t a;
        a.steer = req.steer_angle;
        a.reel = req.reel_angle;
        expected_torques.push_back(restoring_torque(a));
      end
      if (rsp.valid && rsp.ready) begin
        torque_rsp_t e;
        if (expected_torques.size() == 0) begin
          $error("result with no request outstanding");
          fails = fails + 1;
        end else begin
          e = expected_torques.pop_front();
          if (rsp.wrapped_angle !== e.wrapped) begin
            $error("wrapped_angle expected %0d got %0d", e.wrapped, rsp.wrapped_angle);
            fails = fails + 1;
          end
          if (rsp.torque !== e.torque) begin
            $error("torque expected %0d got %0d", e.torque, rsp.torque);
            fails = fails + 1;
          end
          if (rsp.clipped !== e.clipped) begin
            $error("clipped expected %0d got %0d", e.clipped, rsp.clipped);
            fails = fails + 1;
          end
        end
      end
      // watchdog: count cycles with no handshake on either side
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(input reg_index_t idx, input logic [23:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_DEAD_BAND: dead_band_r = val[14:0];
      REG_SPRING_K: spring_k_r = val;
      REG_REEL_RADIUS: reel_radius_r = val[15:0];
      REG_CAM_RADIUS: cam_radius_r = val[15:0];
      default: ;
    endcase
  endtask

  // Hold until every request has been sent and every result scored.
  task automatic drain();
    wait (pending_reqs.size() == 0 && !req.valid && expected_torques.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_req(input logic [31:0] steer, input logic [31:0] reel);
    angle_req_t a;
    a.steer = steer;
    a.reel = reel;
    pending_reqs.push_back(a);
  endtask

  // Mostly in-range steer and reel angles; a share of full-range noise.
  task automatic add_random(input int n);
    logic [31:0] s, r;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: s = $urandom();
        2: s = 32'(int'(dead_band_r) * 128) * ($urandom_range(0, 1) ? 1 : -1);
        default: s = 32'($signed($urandom_range(0, 8000000)) - 4000000);
      endcase
      r = ($urandom_range(0, 3) == 0) ? $urandom()
                                      : 32'($signed($urandom_range(0, 8000000)) - 4000000);
      add_req(s, r);
    end
  endtask

  task automatic set_regs(input logic [14:0] db, input logic [23:0] k,
                          input logic [15:0] rr, input logic [15:0] cr);
    write_reg(REG_DEAD_BAND, 24'(db));
    write_reg(REG_SPRING_K, k);
    write_reg(REG_REEL_RADIUS, 24'(rr));
    write_reg(REG_CAM_RADIUS, 24'(cr));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero, wrap edges, dead band boundary, full-scale fields.
    add_req(32'd0, 32'd0);
    add_req(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_req(32'h8000_0000, 32'h8000_0000);
    add_req(32'd3294199, 32'd1048576);
    add_req(32'd3294200, 32'd1048576);
    add_req(-32'sd3294199, -32'sd1048576);
    add_req(32'd6588398, 32'd0);
    add_req(-32'sd6588398, 32'd5);
    add_req(32'(1425 * 128), 32'd0);
    add_req(32'(1425 * 128 - 1), 32'd0);
    add_req(-32'sd182400, 32'd0);
    add_req(32'd1, 32'hFFFF_FFFF);
    add_req(32'hFFFF_FFFF, 32'd1);
    drain();

    // Saturating settings: both torque limits should clip.
    set_regs(15'd0, 24'hFF_FFFF, 16'hFFFF, 16'hFFFF);
    add_req(32'd1000000, 32'h7FFF_FFFF);
    add_req(-32'sd1000000, 32'h7FFF_FFFF);
    add_req(32'd1000000, 32'h8000_0000);
    add_req(32'd3000000, 32'h7FFF_FFFF);
    add_random(300);
    drain();

    // Dead band above pi: folded sine is used with its own sign.
    set_regs(15'd25736, 24'd128000, 16'd983, 16'd2294);
    add_req(32'd3000000, 32'd0);
    add_req(-32'sd3294199, 32'd100000);
    add_random(300);
    drain();

    // Dead band past pi/2 and mid-range values.
    set_regs(15'd20000, 24'd500000, 16'd30000, 16'd40000);
    add_random(300);
    drain();

    // All registers at zero.
    set_regs(15'd0, 24'd0, 16'd0, 16'd0);
    add_random(100);
    drain();

    // Random settings, then back to defaults with no idling to finish.
    set_regs(15'($urandom_range(0, 25736)), 24'($urandom()), 16'($urandom()),
             16'($urandom()));
    add_random(350);
    drain();

    set_regs(DEAD_BAND_RST, SPRING_K_RST, REEL_RADIUS_RST, CAM_RADIUS_RST);
    quiet = 1'b1;
    add_random(300);
    drain();

    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/crt_pkg.sv
rtl/crt_if.sv
rtl/crt_wrap_cell.sv
rtl/crt_cordic_cell.sv
rtl/cam_spring_restoring_torque_unit.sv
sim/tb_top.sv
